@@ hw/rtl/acs_pkg.sv @@
// Shared constants, codes and control types for the accumulator CPU step block.
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;

  localparam int PROG_DEPTH  = 4096;
  localparam int DATA_DEPTH  = 65536;
  localparam int STACK_DEPTH = 16;
  localparam int NUM_REGS    = 16;

  localparam int WORD_W = 16;
  localparam int PC_W   = 12;
  localparam int ACT_W  = 2;
  localparam int LVL_W  = 4;
  localparam int PA_W   = $clog2(PROG_DEPTH);
  localparam int DA_W   = $clog2(DATA_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int RA_W   = $clog2(NUM_REGS);

  // Immediate loads always land in this register.
  localparam logic [RA_W-1:0] IMM_REG = RA_W'(10);

  // Memory operation control bits of the instruction word
  localparam int BIT_CLR   = 6;
  localparam int BIT_STORE = 7;
  localparam int BIT_NEG   = 8;
  localparam int BIT_INC   = 9;
  localparam int BIT_ADD   = 10;
  localparam int BIT_SHR   = 11;

  typedef enum logic [ACT_W-1:0] {
    ACT_PROG = 2'd0,
    ACT_DATA = 2'd1,
    ACT_EXEC = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    OP_MEM  = 2'b00,
    OP_CALL = 2'b01,
    OP_RET  = 2'b10,
    OP_IMM  = 2'b11
  } op_t;

  typedef struct packed {
    logic capture;     // beat accepted: snapshot pc and stack index
    logic prog_we;     // program word load
    logic data_we;     // data word load
    logic fetch_re;    // start program memory read
    logic fetch_step;  // decode and update architectural state
    logic mem_step;    // finish memory operation and emit
    logic load_emit;   // emit the result of a load or no-op beat
  } ctrl_cmd_t;

  typedef struct packed {
    logic memop;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/acs_if.sv @@
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface acs_in_if import acs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [WORD_W-1:0] load_addr;
  logic [WORD_W-1:0] load_word;

  modport source (output valid, action, load_addr, load_word, input ready);
  modport sink   (input valid, action, load_addr, load_word, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          fetch_addr;
  logic [WORD_W-1:0]        fetched_word;
  logic [LVL_W-1:0]         stack_level;
  logic signed [WORD_W-1:0] acc_value;
  logic [WORD_W-1:0]        mem_addr;
  logic [WORD_W-1:0]        mem_rdata;
  logic                     mem_wrote;
  logic                     did_memop;

  modport source (output valid, fetch_addr, fetched_word, stack_level, acc_value,
                  mem_addr, mem_rdata, mem_wrote, did_memop, input ready);
  modport sink   (input valid, fetch_addr, fetched_word, stack_level, acc_value,
                  mem_addr, mem_rdata, mem_wrote, did_memop, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/acs_ram.sv @@
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps
`default_nettype none
module acs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/acs_ctrl.sv @@
// Step sequencer: accepts beats and walks fetch, memory and emit phases.
`timescale 1ns / 1ps
`default_nettype none
module acs_ctrl import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] action,
  output logic             in_ready,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_MEM   = 4'b0100,
    S_LDONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    cmd.capture    = accept;
    cmd.prog_we    = accept && (action == ACT_PROG);
    cmd.data_we    = accept && (action == ACT_DATA);
    cmd.fetch_re   = accept && (action == ACT_EXEC);
    // a memory op may leave FETCH while the output is busy; it emits in MEM
    cmd.fetch_step = (state == S_FETCH) && (status.memop || status.out_free);
    cmd.mem_step   = (state == S_MEM) && status.out_free;
    cmd.load_emit  = (state == S_LDONE) && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_EXEC) ? S_FETCH : S_LDONE;
        end
      end
      S_FETCH: begin
        if (cmd.fetch_step) begin
          state_next = status.memop ? S_MEM : S_IDLE;
        end
      end
      S_MEM: begin
        if (cmd.mem_step) begin
          state_next = S_IDLE;
        end
      end
      S_LDONE: begin
        if (cmd.load_emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/acs_dp.sv @@
// Datapath: memories, register file, return stack, accumulator, result register.
`timescale 1ns / 1ps
`default_nettype none
module acs_dp import acs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [WORD_W-1:0] load_addr,
  input  logic [WORD_W-1:0] load_word,
  output dp_status_t        status,
  acs_out_if.source         rsp
);

  logic [PC_W-1:0]   pc, ip, pc_inc;
  logic [SP_W-1:0]   sp, sl, sp_inc, sp_dec;
  logic [WORD_W-1:0] acc, acc_next, acc_clr, acc_sum, operand, addr;
  logic [WORD_W-1:0] regs [NUM_REGS];
  logic [PC_W-1:0]   stack [STACK_DEPTH];

  logic [WORD_W-1:0] ir, data_rdata;
  op_t               op;
  logic [RA_W-1:0]   rega;
  logic              memop;

  logic              d_we;
  logic [DA_W-1:0]   d_waddr;
  logic [WORD_W-1:0] d_wdata;
  logic              d_re;

  logic              out_valid;
  logic              emit_fetch;
  logic              emit_any;

  // program and data memories
  acs_ram #(.WIDTH(WORD_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (cmd.prog_we),
    .waddr (load_addr[PA_W-1:0]),
    .wdata (load_word),
    .re    (cmd.fetch_re),
    .raddr (pc[PA_W-1:0]),
    .rdata (ir)
  );

  assign d_we    = cmd.data_we || (cmd.mem_step && ir[BIT_STORE]);
  assign d_waddr = cmd.data_we ? load_addr[DA_W-1:0] : addr[DA_W-1:0];
  assign d_wdata = cmd.data_we ? load_word : acc_next;
  assign d_re    = cmd.fetch_step && memop;

  acs_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_data (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (regs[rega][DA_W-1:0]),
    .rdata (data_rdata)
  );

  // decode; the program read data holds until the next fetch
  assign op     = op_t'(ir[3:2]);
  assign rega   = ir[12 +: RA_W];
  assign memop  = (op == OP_MEM) || (op == OP_RET);
  assign pc_inc = ip + PC_W'(1);
  assign sp_inc = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + SP_W'(1);
  assign sp_dec = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - SP_W'(1);

  // clear, negate, add, arithmetic shift, in that order
  assign acc_clr  = ir[BIT_CLR] ? '0 : acc;
  assign operand  = ir[BIT_NEG] ? (WORD_W'(0) - data_rdata) : data_rdata;
  assign acc_sum  = ir[BIT_ADD] ? (acc_clr + operand) : acc_clr;
  assign acc_next = ir[BIT_SHR] ? {acc_sum[WORD_W-1], acc_sum[WORD_W-1:1]} : acc_sum;

  assign status.memop    = memop;
  assign status.out_free = !out_valid || rsp.ready;

  assign emit_fetch = cmd.fetch_step && !memop;
  assign emit_any   = emit_fetch || cmd.mem_step || cmd.load_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pc        <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (cmd.fetch_step) begin
        case (op)
          OP_IMM: begin
            regs[IMM_REG] <= WORD_W'(ir[15:4]);
            pc            <= pc_inc;
          end
          OP_CALL: begin
            sp <= sp_inc;
            pc <= ir[15:4];
          end
          OP_RET: begin
            sp <= sp_dec;
            pc <= stack[sp_dec];
            if (ir[BIT_INC]) begin
              regs[rega] <= regs[rega] + WORD_W'(1);
            end
          end
          default: begin
            pc <= pc_inc;
            if (ir[BIT_INC]) begin
              regs[rega] <= regs[rega] + WORD_W'(1);
            end
          end
        endcase
      end
      if (cmd.mem_step) begin
        acc <= acc_next;
      end
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_step && (op == OP_CALL)) begin
      stack[sp] <= pc_inc;
    end
  end

  // step snapshot and memory address, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ip <= pc;
      sl <= sp;
    end
    if (cmd.fetch_step) begin
      addr <= regs[rega];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_any) begin
      rsp.fetch_addr   <= ip;
      rsp.stack_level  <= LVL_W'(sl);
      rsp.fetched_word <= cmd.load_emit ? '0 : ir;
      rsp.acc_value    <= cmd.mem_step ? $signed(acc_next) : $signed(acc);
      rsp.mem_addr     <= cmd.mem_step ? addr : '0;
      rsp.mem_rdata    <= cmd.mem_step ? data_rdata : '0;
      rsp.mem_wrote    <= cmd.mem_step && ir[BIT_STORE];
      rsp.did_memop    <= cmd.mem_step;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

@@ hw/rtl/accumulator_cpu_step_top.sv @@
// Steps: load and no-op beats are accepted in IDLE and emitted from LDONE; immediate and call
//   beats read the registered program RAM and emit from FETCH; memory ops then read the
//   registered data RAM and emit from MEM. A new beat is taken only in IDLE, once the
//   previous result is in the result register, which stalls the step while full and untaken.
// Reset clears accumulator, register file, program counter and stack index at once.
//   Program memory, data memory and return stack are not cleared and hold garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none
module accumulator_cpu_step_top import acs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  acs_in_if.sink    req,
  acs_out_if.source rsp
);

  ctrl_cmd_t  ctl;
  dp_status_t st;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .action   (req.action),
    .in_ready (req.ready),
    .status   (st),
    .cmd      (ctl)
  );

  acs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .load_addr (req.load_addr),
    .load_word (req.load_word),
    .status    (st),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

@@ hw/rtl/acs_checker.sv @@
// Port-level assertions for the accumulator CPU step block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acs_checker import acs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_fetched_word,
  input logic [WORD_W-1:0] out_acc_value,
  input logic              out_mem_wrote,
  input logic              out_did_memop
);

  // a beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_acc_value))
    else $error("result beat dropped or changed while stalled");

  // one step at a time: no second beat right after an accept
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a step is in flight");

  // memory ops come only from plain memory or return instructions
  a_memop_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_did_memop |-> !out_fetched_word[2])
    else $error("memory op reported for immediate or call");

  a_store_memop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mem_wrote |-> out_did_memop &&
      out_fetched_word[BIT_STORE])
    else $error("store reported without a storing memory op");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind accumulator_cpu_step_top acs_checker u_acs_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (req.valid),
  .in_ready         (req.ready),
  .out_valid        (rsp.valid),
  .out_ready        (rsp.ready),
  .out_fetched_word (rsp.fetched_word),
  .out_acc_value    (rsp.acc_value),
  .out_mem_wrote    (rsp.mem_wrote),
  .out_did_memop    (rsp.did_memop)
);
`default_nettype wire

@@ test/acs_step_checker.sv @@
// Checker for the accumulator CPU step block: tracks the CPU state and compares every result beat.
`timescale 1ns / 1ps
module acs_step_checker import acs_pkg::*; (
  input  logic clk,
  input  logic rst,
  acs_in_if    req,
  acs_out_if   rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [PC_W-1:0]          fetch_addr;
    logic [WORD_W-1:0]        fetched_word;
    logic [LVL_W-1:0]         stack_level;
    logic signed [WORD_W-1:0] acc_value;
    logic [WORD_W-1:0]        mem_addr;
    logic [WORD_W-1:0]        mem_rdata;
    logic                     mem_wrote;
    logic                     did_memop;
  } step_res_t;

  // CPU state as the block should hold it
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] gpr [NUM_REGS];
  logic [PC_W-1:0]   pc;
  logic [SP_W-1:0]   sp;
  logic [PC_W-1:0]   ret_stack [STACK_DEPTH];
  logic [WORD_W-1:0] prog_mem [PROG_DEPTH];
  logic [WORD_W-1:0] data_mem [DATA_DEPTH];

  step_res_t expected_steps[$];
  step_res_t want, got;
  int        n_bad = 0;

  assign mismatches = n_bad;

  task automatic predict_step(input act_t act, input logic [WORD_W-1:0] la,
                              input logic [WORD_W-1:0] lw, output step_res_t r);
    logic [WORD_W-1:0] ir, rd, opnd, addr;
    logic [RA_W-1:0]   ra;
    op_t               op;
    r = '0;
    r.fetch_addr  = pc;
    r.stack_level = sp;
    if (act != ACT_EXEC) begin
      if (act == ACT_PROG) prog_mem[la[PA_W-1:0]] = lw;
      else if (act == ACT_DATA) data_mem[la] = lw;
    end else begin
      ir = prog_mem[pc];
      r.fetched_word = ir;
      pc = pc + 1'b1;
      op = op_t'(ir[3:2]);
      case (op)
        OP_IMM: gpr[IMM_REG] = {4'h0, ir[15:4]};
        OP_CALL: begin
          ret_stack[sp] = pc;
          sp = sp + 1'b1;
          pc = ir[15:4];
        end
        OP_RET: begin
          sp = sp - 1'b1;
          pc = ret_stack[sp];
        end
        default: ;
      endcase
      if (op == OP_MEM || op == OP_RET) begin
        if (ir[BIT_CLR]) acc = '0;
        ra   = ir[15:12];
        addr = gpr[ra];
        rd   = data_mem[addr];
        opnd = ir[BIT_NEG] ? WORD_W'(0) - rd : rd;
        if (ir[BIT_INC]) gpr[ra] = gpr[ra] + 1'b1;
        if (ir[BIT_ADD]) acc = acc + opnd;
        if (ir[BIT_SHR]) acc = {acc[WORD_W-1], acc[WORD_W-1:1]};
        if (ir[BIT_STORE]) data_mem[addr] = acc;
        r.mem_addr  = addr;
        r.mem_rdata = rd;
        r.mem_wrote = ir[BIT_STORE];
        r.did_memop = 1'b1;
      end
    end
    r.acc_value = acc;
  endtask

  task automatic cmp_field(input string name, input logic [WORD_W-1:0] exp_v,
                           input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      if (n_bad < 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc = '0;
      pc  = '0;
      sp  = '0;
      foreach (gpr[i]) gpr[i] = '0;
      expected_steps.delete();
    end else begin
      if (req.valid && req.ready) begin
        predict_step(act_t'(req.action), req.load_addr, req.load_word, want);
        expected_steps.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.fetch_addr, rsp.fetched_word, rsp.stack_level, rsp.acc_value,
               rsp.mem_addr, rsp.mem_rdata, rsp.mem_wrote, rsp.did_memop};
        if (expected_steps.size() == 0) begin
          if (n_bad < 10) $display("[%0t] result beat with nothing expected", $time);
          n_bad++;
        end else begin
          want = expected_steps.pop_front();
          cmp_field("fetch_addr",   16'(want.fetch_addr),   16'(got.fetch_addr));
          cmp_field("fetched_word", want.fetched_word,      got.fetched_word);
          cmp_field("stack_level",  16'(want.stack_level),  16'(got.stack_level));
          cmp_field("acc_value",    want.acc_value,         got.acc_value);
          cmp_field("mem_addr",     want.mem_addr,          got.mem_addr);
          cmp_field("mem_rdata",    want.mem_rdata,         got.mem_rdata);
          cmp_field("mem_wrote",    16'(want.mem_wrote),    16'(got.mem_wrote));
          cmp_field("did_memop",    16'(want.did_memop),    16'(got.did_memop));
        end
      end
    end
    outstanding <= expected_steps.size();
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the accumulator CPU step block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;
  import acs_pkg::*;

  localparam int N_ITEMS         = 1500;
  localparam int CALM_AFTER      = 1350;
  localparam int WATCHDOG_CYCLES = 200;

  localparam logic [WORD_W-1:0] F_CLR   = WORD_W'(1) << BIT_CLR;
  localparam logic [WORD_W-1:0] F_STORE = WORD_W'(1) << BIT_STORE;
  localparam logic [WORD_W-1:0] F_NEG   = WORD_W'(1) << BIT_NEG;
  localparam logic [WORD_W-1:0] F_INC   = WORD_W'(1) << BIT_INC;
  localparam logic [WORD_W-1:0] F_ADD   = WORD_W'(1) << BIT_ADD;
  localparam logic [WORD_W-1:0] F_SHR   = WORD_W'(1) << BIT_SHR;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  acs_in_if  req_ch ();
  acs_out_if rsp_ch ();

  logic              in_valid  = 1'b0;
  act_t              in_action = ACT_NONE;
  logic [WORD_W-1:0] in_addr   = '0;
  logic [WORD_W-1:0] in_word   = '0;
  logic              out_ready = 1'b0;

  assign req_ch.valid     = in_valid;
  assign req_ch.action    = in_action;
  assign req_ch.load_addr = in_addr;
  assign req_ch.load_word = in_word;
  assign rsp_ch.ready     = out_ready;

  int mismatches, outstanding;

  accumulator_cpu_step_top dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  acs_step_checker chk (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Legality tracking: what has been written, and where the program counter goes.
  logic [WORD_W-1:0] pm [PROG_DEPTH];
  bit                pm_ok [PROG_DEPTH];
  bit                dm_ok [DATA_DEPTH];
  logic [PC_W-1:0]   rs [STACK_DEPTH];
  bit                rs_ok [STACK_DEPTH];
  logic [WORD_W-1:0] rf [NUM_REGS];
  logic [PC_W-1:0]   pc = '0;
  logic [SP_W-1:0]   sp = '0;

  bit calm = 1'b0;
  int items_sent = 0;
  int n_prog = 0, n_data = 0, n_none = 0;
  int n_op [4];
  int stall_left = 0;
  int idle_cycles = 0;

  initial foreach (rf[i]) rf[i] = '0;

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input act_t a, input logic [WORD_W-1:0] ad, input logic [WORD_W-1:0] w);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= a;
    in_addr   <= ad;
    in_word   <= w;
    do @(posedge clk); while (!req_ch.ready);
    case (a)
      ACT_PROG: begin
        pm[ad[PA_W-1:0]]    = w;
        pm_ok[ad[PA_W-1:0]] = 1'b1;
        n_prog++;
      end
      ACT_DATA: begin
        dm_ok[ad] = 1'b1;
        n_data++;
      end
      ACT_NONE: n_none++;
      default: ;
    endcase
    if (a != ACT_NONE) items_sent++;
  endtask

  // Program load at a 12-bit address; the upper address bits are don't-care.
  task automatic load_prog(input logic [PC_W-1:0] a, input logic [WORD_W-1:0] w);
    send(ACT_PROG, {4'($urandom), a}, w);
  endtask

  // Run one instruction, first loading whatever it would otherwise read unwritten.
  task automatic exec_one(input logic [WORD_W-1:0] iw, input bit reload);
    logic [WORD_W-1:0] ir;
    logic [PC_W-1:0]   pc_next;
    logic [RA_W-1:0]   ra;
    op_t               op;
    if (reload || !pm_ok[pc]) load_prog(pc, iw);
    ir = pm[pc];
    if (op_t'(ir[3:2]) == OP_RET && !rs_ok[SP_W'(sp - 1'b1)]) begin
      ir[3:2] = OP_MEM;
      load_prog(pc, ir);
    end
    op = op_t'(ir[3:2]);
    ra = ir[15:12];
    if ((op == OP_MEM || op == OP_RET) && !dm_ok[rf[ra]])
      send(ACT_DATA, rf[ra], 16'($urandom));
    send(ACT_EXEC, 16'($urandom), 16'($urandom));
    n_op[op]++;
    pc_next = pc + 1'b1;
    case (op)
      OP_IMM: rf[IMM_REG] = {4'h0, ir[15:4]};
      OP_CALL: begin
        rs[sp]    = pc_next;
        rs_ok[sp] = 1'b1;
        sp        = sp + 1'b1;
        pc_next   = ir[15:4];
      end
      OP_RET: begin
        sp      = sp - 1'b1;
        pc_next = rs[sp];
      end
      default: ;
    endcase
    if ((op == OP_MEM || op == OP_RET) && ir[BIT_INC]) rf[ra] = rf[ra] + 1'b1;
    pc = pc_next;
  endtask

  function automatic logic [WORD_W-1:0] mem_word(input op_t op, input logic [RA_W-1:0] r,
                                                 input logic [WORD_W-1:0] flags);
    return {r, 12'h000} | flags | {12'h000, op, 2'b00};
  endfunction

  function automatic logic [WORD_W-1:0] jmp_word(input op_t op, input logic [PC_W-1:0] im);
    return {im, op, 2'b00};
  endfunction

  function automatic logic [WORD_W-1:0] rand_insn(input int call_w, input int ret_w);
    logic [WORD_W-1:0] w;
    int pick;
    w    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w[3:2] = OP_IMM;
    end else if (pick < 12 + call_w) begin
      w[3:2] = OP_CALL;
      // half the calls land in a small, well-populated code region
      if ($urandom_range(0, 1) == 1) w[15:4] = 12'($urandom_range(0, 63));
    end else if (pick < 12 + call_w + ret_w) begin
      w[3:2] = OP_RET;
    end else begin
      w[3:2] = OP_MEM;
    end
    return w;
  endfunction

  initial begin
    int pick, call_w, ret_w;
    foreach (n_op[i]) n_op[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners of the fields and each operation
    send(ACT_NONE, 16'hffff, 16'hffff);
    send(ACT_DATA, 16'hffff, 16'h8000);
    send(ACT_PROG, 16'hffff, mem_word(OP_MEM, 4'h0, F_ADD));   // upper bits ignored: lands at 0xfff
    send(ACT_DATA, 16'h0000, 16'h7fff);
    exec_one(mem_word(OP_MEM, 4'h0, F_CLR | F_ADD), 1'b1);
    exec_one(mem_word(OP_MEM, 4'h0, F_ADD | F_INC), 1'b1);     // add overflow wraps
    exec_one(jmp_word(OP_IMM, 12'hfff), 1'b1);                 // largest immediate
    send(ACT_DATA, 16'h0fff, 16'h8000);
    exec_one(mem_word(OP_MEM, IMM_REG, F_CLR | F_NEG | F_ADD), 1'b1);  // -0x8000 stays 0x8000
    exec_one(mem_word(OP_MEM, IMM_REG, F_SHR | F_STORE), 1'b1);        // shift keeps the sign
    exec_one(mem_word(OP_MEM, IMM_REG, F_CLR | F_STORE | F_NEG | F_INC | F_ADD | F_SHR), 1'b1);
    exec_one(jmp_word(OP_CALL, 12'hfff), 1'b1);
    exec_one(16'h0000, 1'b0);                                  // last program word, pc wraps to 0
    exec_one(mem_word(OP_RET, 4'h1, F_STORE | F_ADD), 1'b1);
    exec_one(mem_word(OP_RET, 4'h2, F_ADD), 1'b1);             // empty stack: becomes a memory op
    send(ACT_NONE, 16'h0000, 16'h0000);

    // Random programs, with the call/return mix shifting between phases
    while (items_sent < N_ITEMS) begin
      calm = (items_sent >= CALM_AFTER);
      case ((items_sent / 250) % 3)
        0:       begin call_w = 30; ret_w = 10; end
        1:       begin call_w = 10; ret_w = 30; end
        default: begin call_w = 20; ret_w = 20; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        if ($urandom_range(0, 1) == 1)
          load_prog(pc + 12'($urandom_range(1, 8)), rand_insn(call_w, ret_w));
        else
          send(ACT_PROG, 16'($urandom), rand_insn(call_w, ret_w));
      end else if (pick < 20) begin
        if ($urandom_range(0, 1) == 1)
          send(ACT_DATA, 16'($urandom), 16'($urandom));
        else
          send(ACT_DATA, 16'(rf[$urandom_range(0, NUM_REGS - 1)] + $urandom_range(0, 7)),
               16'($urandom));
      end else if (pick < 23) begin
        send(ACT_NONE, 16'($urandom), 16'($urandom));
      end else begin
        exec_one(rand_insn(call_w, ret_w), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d program loads, %0d data loads, %0d idle actions and %0d instructions",
             n_prog, n_data, n_none, n_op[OP_MEM] + n_op[OP_CALL] + n_op[OP_RET] + n_op[OP_IMM]);
    $display("  (%0d memory ops, %0d calls, %0d returns, %0d immediates), %0d field mismatches",
             n_op[OP_MEM], n_op[OP_CALL], n_op[OP_RET], n_op[OP_IMM], mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
